// ===== src/bgj_pkg.sv =====
// Package for the bracket group joiner: sizes, character codes, result kinds
// and the command and result records passed between the front and back parts.
// No dependencies.
package bgj_pkg;

  localparam int STACK_DEPTH    = 16;
  localparam int TOKEN_CAPACITY = 64;

  localparam int LevelW    = $clog2(STACK_DEPTH + 1);
  localparam int StackIdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CountW    = $clog2(TOKEN_CAPACITY + 1);
  localparam int StoreIdxW = (TOKEN_CAPACITY > 1) ? $clog2(TOKEN_CAPACITY) : 1;
  localparam int CharW     = 16;

  localparam logic [CharW-1:0] CH_OPEN_ROUND   = 16'h0028;
  localparam logic [CharW-1:0] CH_OPEN_SQUARE  = 16'h005B;
  localparam logic [CharW-1:0] CH_CLOSE_ROUND  = 16'h0029;
  localparam logic [CharW-1:0] CH_CLOSE_SQUARE = 16'h005D;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_UNMATCHED = 2'd1,
    KIND_OVERFLOW  = 2'd2
  } kind_e;

  typedef struct packed {
    logic                 append;
    logic [StoreIdxW-1:0] app_idx;
    logic [CharW-1:0]     ch;
    logic                 flush;
    logic [CountW-1:0]    flush_len;
    logic                 emit;
    kind_e                kind;
    logic                 emit_last;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ch;
    logic             last;
  } out_t;

endpackage

// ===== src/bgj_front.sv =====
// Front part of the bracket group joiner: bracket stack, store fill count and
// line state; turns each accepted item into at most one command for the back part.
// Depends on bgj_pkg.
module bgj_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [15:0]              in_char_i,
  input  logic                     in_token_last_i,
  input  logic                     literal_i,
  input  logic                     line_last_i,
  output logic                     cmd_valid_o,
  output bgj_pkg::cmd_t            cmd_o
);
  import bgj_pkg::*;

  logic [STACK_DEPTH-1:0] stk_q;
  logic [LevelW-1:0]      lvl_q, lvl_d, lvl_n, lvl_m1;
  logic [CountW-1:0]      cnt_q, cnt_d, cnt_app;
  logic                   fail_q, fail_d;
  logic                   stk_we, err, app, flush;
  kind_e                  err_kind;
  logic                   is_open, is_close, top, store_full, stack_full;
  cmd_t                   cmd;

  assign is_open    = (in_char_i == CH_OPEN_ROUND) || (in_char_i == CH_OPEN_SQUARE);
  assign is_close   = (in_char_i == CH_CLOSE_ROUND) || (in_char_i == CH_CLOSE_SQUARE);
  assign store_full = (cnt_q == CountW'(TOKEN_CAPACITY));
  assign stack_full = (lvl_q == LevelW'(STACK_DEPTH));
  assign lvl_m1     = lvl_q - LevelW'(1);
  assign top        = stk_q[lvl_m1[StackIdxW-1:0]];

  always_comb begin
    lvl_d    = lvl_q;
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    lvl_n    = lvl_q;
    cnt_app  = cnt_q;
    stk_we   = 1'b0;
    err      = 1'b0;
    err_kind = KIND_CHAR;
    app      = 1'b0;
    flush    = 1'b0;
    cmd      = '0;
    if (!fail_q) begin
      if (literal_i) begin
        cmd.emit      = 1'b1;
        cmd.kind      = KIND_CHAR;
        cmd.ch        = in_char_i;
        cmd.emit_last = in_token_last_i;
      end else if (is_open) begin
        if (stack_full) begin
          err      = 1'b1;
          err_kind = KIND_OVERFLOW;
        end else begin
          if (lvl_q != '0) begin
            if (store_full) begin
              err      = 1'b1;
              err_kind = KIND_OVERFLOW;
            end else begin
              app = 1'b1;
            end
          end else begin
            flush = 1'b1;
          end
          if (!err) begin
            stk_we = 1'b1;
            lvl_n  = lvl_q + LevelW'(1);
          end
        end
      end else if (is_close) begin
        if (lvl_q == '0) begin
          err      = 1'b1;
          err_kind = KIND_UNMATCHED;
        end else begin
          lvl_n = lvl_m1;
          if (top != (in_char_i == CH_CLOSE_SQUARE)) begin
            err      = 1'b1;
            err_kind = KIND_UNMATCHED;
          end else if (lvl_m1 == '0) begin
            flush = 1'b1;
          end else if (store_full) begin
            err      = 1'b1;
            err_kind = KIND_OVERFLOW;
          end else begin
            app = 1'b1;
          end
        end
      end else begin
        if (store_full) begin
          err      = 1'b1;
          err_kind = KIND_OVERFLOW;
        end else begin
          app = 1'b1;
        end
      end
      if (!literal_i) begin
        cnt_app = cnt_q + CountW'(app);
        if (!err && (in_token_last_i || line_last_i) && lvl_n == '0) begin
          flush = 1'b1;
        end
      end
      if (!err && line_last_i && lvl_n != '0) begin
        err      = 1'b1;
        err_kind = KIND_UNMATCHED;
      end
      if (err) begin
        cmd           = '0;
        cmd.emit      = 1'b1;
        cmd.kind      = err_kind;
        lvl_d         = '0;
        cnt_d         = '0;
        fail_d        = 1'b1;
      end else begin
        if (!literal_i) begin
          cmd.append    = app;
          cmd.app_idx   = cnt_q[StoreIdxW-1:0];
          cmd.ch        = in_char_i;
          cmd.flush     = flush && (cnt_app != '0);
          cmd.flush_len = cnt_app;
        end
        lvl_d = lvl_n;
        cnt_d = flush ? '0 : cnt_app;
      end
    end
    if (line_last_i) begin
      lvl_d  = '0;
      cnt_d  = '0;
      fail_d = 1'b0;
    end
  end

  assign cmd_valid_o = accept_i && (cmd.append || cmd.flush || cmd.emit);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q  <= '0;
      cnt_q  <= '0;
      fail_q <= 1'b0;
    end else if (accept_i) begin
      lvl_q  <= lvl_d;
      cnt_q  <= cnt_d;
      fail_q <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && stk_we && !err) begin
      stk_q[lvl_q[StackIdxW-1:0]] <= (in_char_i == CH_OPEN_SQUARE);
    end
  end

endmodule

// ===== src/bgj_cmd_queue.sv =====
// Four-entry command queue between the front and back parts.
// Depends on bgj_pkg.
module bgj_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgj_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bgj_pkg::cmd_t head_o
);
  import bgj_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = 2;
  localparam int CntW  = 3;

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== src/bgj_back.sv =====
// Back part of the bracket group joiner: token store memory, flush drain,
// read stage and the result queue that feeds the output ports.
// Depends on bgj_pkg.
module bgj_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cq_empty_i,
  input  bgj_pkg::cmd_t cq_head_i,
  output logic          cq_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bgj_pkg::out_t head_o
);
  import bgj_pkg::*;

  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 3;

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic [CharW-1:0]   store_q [TOKEN_CAPACITY];
  logic [CharW-1:0]   rd_data_q;
  logic               st_q, st_d;
  logic [CountW-1:0]  idx_q, idx_d, len_q, len_d, idx_p1;
  logic               mem_we, rd_en, credit;

  logic               s1_vld_q, s1_vld_d, s1_mem_q, s1_mem_d, s1_last_q, s1_last_d;
  kind_e              s1_kind_q, s1_kind_d;
  logic [CharW-1:0]   s1_char_q, s1_char_d;

  out_t               oq_q [OutDepth];
  logic [OutPtrW-1:0] owr_q, ord_q;
  logic [OutCntW-1:0] ocnt_q;
  logic               o_pop;
  out_t               o_in;

  assign credit = (ocnt_q + OutCntW'(s1_vld_q)) < OutCntW'(OutDepth);
  assign idx_p1 = idx_q + CountW'(1);

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    len_d     = len_q;
    cq_pop_o  = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    s1_vld_d  = 1'b0;
    s1_mem_d  = 1'b0;
    s1_kind_d = KIND_CHAR;
    s1_char_d = cq_head_i.ch;
    s1_last_d = cq_head_i.emit_last;
    unique case (st_q)
      StIdle: begin
        if (!cq_empty_i) begin
          if (cq_head_i.emit) begin
            if (credit) begin
              cq_pop_o  = 1'b1;
              s1_vld_d  = 1'b1;
              s1_kind_d = cq_head_i.kind;
            end
          end else begin
            cq_pop_o = 1'b1;
            mem_we   = cq_head_i.append;
            if (cq_head_i.flush) begin
              st_d  = StDrain;
              idx_d = '0;
              len_d = cq_head_i.flush_len;
            end
          end
        end
      end
      StDrain: begin
        if (credit) begin
          rd_en     = 1'b1;
          s1_vld_d  = 1'b1;
          s1_mem_d  = 1'b1;
          s1_last_d = (idx_p1 == len_q);
          idx_d     = idx_p1;
          if (idx_p1 == len_q) st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      idx_q    <= '0;
      len_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mem_q  <= s1_mem_d;
    s1_kind_q <= s1_kind_d;
    s1_char_q <= s1_char_d;
    s1_last_q <= s1_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[cq_head_i.app_idx] <= cq_head_i.ch;
    if (rd_en) rd_data_q <= store_q[idx_q[StoreIdxW-1:0]];
  end

  assign o_in.kind = s1_kind_q;
  assign o_in.ch   = s1_mem_q ? rd_data_q : s1_char_q;
  assign o_in.last = s1_last_q;

  assign empty_o = (ocnt_q == '0);
  assign head_o  = oq_q[ord_q];
  assign o_pop   = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (s1_vld_q) owr_q <= owr_q + OutPtrW'(1);
      if (o_pop) ord_q <= ord_q + OutPtrW'(1);
      ocnt_q <= ocnt_q + OutCntW'(s1_vld_q) - OutCntW'(o_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) oq_q[owr_q] <= o_in;
  end

endmodule

// ===== src/bracket_group_joiner_unit.sv =====
// Bracket group joiner: one character per item in, joined tokens out.
// Instantiates bgj_front, bgj_cmd_queue and bgj_back; depends on bgj_pkg.
//
// Input side is a queue: an item (character plus token-end, literal and
// line-end flags) enters on a clock edge with push high and full low.
// Result side is a queue: the oldest result sits on kind_o, out_char_o and
// out_token_last_o while empty is low and leaves on an edge with pop high.
// The front takes one item a cycle while full is low and turns it into at
// most one command; a four-entry command queue decouples it from the
// back, which writes the 64-entry token store and drains a flush one
// stored character per cycle while the result queue has room, through a
// registered memory read into a four-entry result queue.
// A literal or error result passes through the command queue, the read
// stage register and the result queue; a flushed token also passes the
// single store read port, so the back takes no new command while draining.
// When pop stays low the result queue fills, the back holds, the command
// queue fills and full rises; nothing is dropped.
// Reset empties both queues, clears the bracket depth, store count and
// failed-line flag; no clearing pass is needed.
module bracket_group_joiner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_char_i,
  input  logic        in_token_last_i,
  input  logic        literal_i,
  input  logic        line_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [15:0] out_char_o,
  output logic        out_token_last_o
);
  import bgj_pkg::*;

  logic accept, cmd_valid, cq_full, cq_empty, cq_pop;
  cmd_t cmd, cq_head;
  out_t res;

  assign full   = cq_full;
  assign accept = push && !cq_full;

  bgj_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_char_i       (in_char_i),
    .in_token_last_i (in_token_last_i),
    .literal_i       (literal_i),
    .line_last_i     (line_last_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  bgj_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .cmd_i   (cmd),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .head_o  (cq_head)
  );

  bgj_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_empty_i (cq_empty),
    .cq_head_i  (cq_head),
    .cq_pop_o   (cq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (res)
  );

  assign kind_o           = res.kind;
  assign out_char_o       = res.ch;
  assign out_token_last_o = res.last;

endmodule

// ===== tb/sv/bgj_token_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bracket group joiner: watches both queue sides, predicts the
// joined tokens and errors for every accepted item and compares them in order.
// Depends on bgj_pkg.
module bgj_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] in_char_i,
  input  logic        in_token_last_i,
  input  logic        literal_i,
  input  logic        line_last_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind_o,
  input  logic [15:0] out_char_o,
  input  logic        out_token_last_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          live_items_o,
  output int          results_o
);
  import bgj_pkg::*;

  logic             open_square_q [STACK_DEPTH];
  int               depth_q;
  logic [CharW-1:0] store_q [TOKEN_CAPACITY];
  int               count_q;
  logic             line_dead_q;
  out_t             token_out_q [$];
  out_t             flush_q [$];

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    fail_count_o++;
  endtask

  task automatic check_result();
    out_t want;
    results_o++;
    if (token_out_q.size() == 0) begin
      report("unexpected result kind", '0, 16'(kind_o));
      return;
    end
    want = token_out_q.pop_front();
    if (kind_o !== want.kind) report("kind", 16'(want.kind), 16'(kind_o));
    if (out_char_o !== want.ch) report("out_char", want.ch, out_char_o);
    if (out_token_last_o !== want.last)
      report("out_token_last", 16'(want.last), 16'(out_token_last_o));
  endtask

  task automatic drain_store();
    for (int i = 0; i < count_q; i++)
      flush_q.insert(flush_q.size(),
                     out_t'{kind: KIND_CHAR, ch: store_q[i], last: (i + 1 == count_q)});
    count_q = 0;
  endtask

  function automatic logic store_char(input logic [CharW-1:0] ch);
    if (count_q >= TOKEN_CAPACITY) return 1'b0;
    store_q[count_q] = ch;
    count_q++;
    return 1'b1;
  endfunction

  // KIND_CHAR in fault means the item raised no error
  task automatic join_item(input logic [CharW-1:0] ch, input logic tok_end, input logic lit,
                           input logic line_end);
    kind_e fault;
    fault = KIND_CHAR;
    flush_q.delete();
    if (line_dead_q) begin
      if (line_end) begin
        depth_q     = 0;
        count_q     = 0;
        line_dead_q = 1'b0;
      end
      return;
    end
    live_items_o++;
    if (lit) begin
      flush_q.insert(flush_q.size(), out_t'{kind: KIND_CHAR, ch: ch, last: tok_end});
    end else begin
      if (ch == CH_OPEN_ROUND || ch == CH_OPEN_SQUARE) begin
        if (depth_q >= STACK_DEPTH) begin
          fault = KIND_OVERFLOW;
        end else begin
          if (depth_q > 0) begin
            if (!store_char(ch)) fault = KIND_OVERFLOW;
          end else begin
            drain_store();
          end
          if (fault == KIND_CHAR) begin
            open_square_q[depth_q] = (ch == CH_OPEN_SQUARE);
            depth_q++;
          end
        end
      end else if (ch == CH_CLOSE_ROUND || ch == CH_CLOSE_SQUARE) begin
        if (depth_q == 0) begin
          fault = KIND_UNMATCHED;
        end else begin
          depth_q--;
          if (open_square_q[depth_q] != (ch == CH_CLOSE_SQUARE)) fault = KIND_UNMATCHED;
          else if (depth_q == 0) drain_store();
          else if (!store_char(ch)) fault = KIND_OVERFLOW;
        end
      end else if (!store_char(ch)) begin
        fault = KIND_OVERFLOW;
      end
      if (fault == KIND_CHAR && (tok_end || line_end) && depth_q == 0) drain_store();
    end
    if (fault == KIND_CHAR && line_end && depth_q != 0) fault = KIND_UNMATCHED;
    if (fault != KIND_CHAR) begin
      token_out_q.insert(token_out_q.size(), out_t'{kind: fault, ch: '0, last: 1'b0});
      count_q     = 0;
      depth_q     = 0;
      line_dead_q = 1'b1;
    end else begin
      foreach (flush_q[i]) token_out_q.insert(token_out_q.size(), flush_q[i]);
    end
    if (line_end) begin
      depth_q     = 0;
      count_q     = 0;
      line_dead_q = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      = 0;
      count_q      = 0;
      line_dead_q  = 1'b0;
      token_out_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      live_items_o = 0;
      results_o    = 0;
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) join_item(in_char_i, in_token_last_i, literal_i, line_last_i);
      pending_o = token_out_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_bracket_group_joiner_unit.sv =====
`timescale 1ns / 1ps
// Top of the bracket group joiner testbench: clock, reset, line stimulus and
// random pop pressure. Depends on bgj_pkg, bgj_token_checker and the block.
module tb_bracket_group_joiner_unit;
  import bgj_pkg::*;

  typedef struct {
    logic [15:0] ch;
    logic        tl;
    logic        lit;
    logic        ll;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] in_char_i;
  logic        in_token_last_i;
  logic        literal_i;
  logic        line_last_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [15:0] out_char_o;
  logic        out_token_last_o;

  int          fail_count;
  int          pending;
  int          live_items;
  int          results;
  int          push_idle_pct;
  int          pop_idle_pct;
  int          lines_sent;
  int          items_sent;
  item_t       line_q [$];
  bit          open_sq [$];

  bracket_group_joiner_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_char_i        (in_char_i),
    .in_token_last_i  (in_token_last_i),
    .literal_i        (literal_i),
    .line_last_i      (line_last_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .out_char_o       (out_char_o),
    .out_token_last_o (out_token_last_o)
  );

  bgj_token_checker i_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_char_i        (in_char_i),
    .in_token_last_i  (in_token_last_i),
    .literal_i        (literal_i),
    .line_last_i      (line_last_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .out_char_o       (out_char_o),
    .out_token_last_o (out_token_last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .live_items_o     (live_items),
    .results_o        (results)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (rst_ni) pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    do begin
      if ($urandom_range(1)) c = 16'($urandom_range(16'h20, 16'h7e));
      else c = 16'($urandom_range(0, 16'hffff));
    end while (c inside {CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_CLOSE_ROUND, CH_CLOSE_SQUARE});
    return c;
  endfunction

  function automatic logic [15:0] any_bracket();
    case ($urandom_range(3))
      0:       return CH_OPEN_ROUND;
      1:       return CH_OPEN_SQUARE;
      2:       return CH_CLOSE_ROUND;
      default: return CH_CLOSE_SQUARE;
    endcase
  endfunction

  task automatic add(input logic [15:0] ch, input logic tl, input logic lit, input logic ll);
    line_q.insert(line_q.size(), item_t'{ch: ch, tl: tl, lit: lit, ll: ll});
  endtask

  task automatic open_bracket();
    bit sq;
    sq = 1'($urandom_range(1));
    open_sq.insert(open_sq.size(), sq);
    add(sq ? CH_OPEN_SQUARE : CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic close_bracket();
    bit sq;
    sq = open_sq[open_sq.size() - 1];
    open_sq.delete(open_sq.size() - 1);
    add(sq ? CH_CLOSE_SQUARE : CH_CLOSE_ROUND, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic mark_ends();
    line_q[line_q.size() - 1].tl = 1'b1;
    line_q[line_q.size() - 1].ll = 1'b1;
  endtask

  task automatic build_clean_line();
    int n_tok;
    int len;
    int r;
    n_tok = $urandom_range(1, 4);
    repeat (n_tok) begin
      r = $urandom_range(9);
      if (r < 2) begin
        len = $urandom_range(1, 4);
        repeat (len) add(16'($urandom_range(0, 16'hffff)), 1'b0, 1'b1, 1'b0);
      end else if (r < 5) begin
        len = $urandom_range(1, 5);
        repeat (len) add(plain_char(), 1'b0, 1'b0, 1'b0);
      end else begin
        if ($urandom_range(3) == 0) add(plain_char(), 1'b0, 1'b0, 1'b0);
        open_bracket();
        len = $urandom_range(1, 10);
        repeat (len) begin
          r = $urandom_range(7);
          if (r == 0 && open_sq.size() < 5) open_bracket();
          else if (r == 1 && open_sq.size() > 1) close_bracket();
          else if (r == 2) add(16'($urandom_range(0, 16'hffff)), 1'($urandom_range(1)), 1'b1, 1'b0);
          else add(plain_char(), ($urandom_range(5) == 0), 1'b0, 1'b0);
        end
        while (open_sq.size() != 0) close_bracket();
        if ($urandom_range(3) == 0) add(plain_char(), 1'b0, 1'b0, 1'b0);
      end
      line_q[line_q.size() - 1].tl = 1'b1;
    end
    mark_ends();
  endtask

  task automatic build_noise_line();
    int len;
    len = $urandom_range(1, 12);
    repeat (len) begin
      add($urandom_range(1) ? any_bracket() : 16'($urandom_range(0, 16'hffff)),
          ($urandom_range(2) == 0), ($urandom_range(7) == 0), 1'b0);
    end
    line_q[line_q.size() - 1].ll = 1'b1;
  endtask

  task automatic build_deep_line();
    int n;
    n = $urandom_range(16, 17);
    repeat (n) open_bracket();
    if (n == 16 && $urandom_range(1)) begin
      while (open_sq.size() != 0) close_bracket();
    end else begin
      open_sq.delete();
      add(plain_char(), 1'b0, 1'b0, 1'b0);
    end
    mark_ends();
  endtask

  task automatic build_long_line();
    int n;
    bit opened;
    opened = 1'($urandom_range(1));
    if (opened) add(CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
    n = $urandom_range(62, 66);
    repeat (n) add(plain_char(), 1'b0, 1'b0, 1'b0);
    if (opened) add(CH_CLOSE_ROUND, 1'b0, 1'b0, 1'b0);
    mark_ends();
  endtask

  task automatic build_random_line();
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      build_clean_line();
      if (r >= 60) line_q[$urandom_range(line_q.size() - 1)].ch = any_bracket();
    end else if (r < 93) begin
      build_noise_line();
    end else if (r < 97) begin
      build_long_line();
    end else begin
      build_deep_line();
    end
  endtask

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push            <= 1'b1;
    in_char_i       <= it.ch;
    in_token_last_i <= it.tl;
    literal_i       <= it.lit;
    line_last_i     <= it.ll;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i]);
    line_q.delete();
    lines_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int target;
    rst_ni          = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    in_char_i       = '0;
    in_token_last_i = 1'b0;
    literal_i       = 1'b0;
    line_last_i     = 1'b0;
    push_idle_pct   = 28;
    pop_idle_pct    = 49;
    lines_sent      = 0;
    items_sent      = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add(16'hffff, 1'b0, 1'b0, 1'b0);
    add(16'h0000, 1'b1, 1'b0, 1'b0);
    add(CH_OPEN_ROUND, 1'b1, 1'b1, 1'b0);
    add(CH_OPEN_SQUARE, 1'b0, 1'b0, 1'b0);
    add(16'h0078, 1'b0, 1'b0, 1'b0);
    add(CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
    add(CH_CLOSE_ROUND, 1'b0, 1'b0, 1'b0);
    add(CH_CLOSE_SQUARE, 1'b1, 1'b0, 1'b1);
    send_line();
    add(CH_CLOSE_ROUND, 1'b1, 1'b0, 1'b0);
    add(16'h0061, 1'b1, 1'b0, 1'b1);
    send_line();
    add(CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
    add(CH_CLOSE_SQUARE, 1'b1, 1'b0, 1'b1);
    send_line();
    add(CH_OPEN_SQUARE, 1'b0, 1'b0, 1'b0);
    add(16'h0071, 1'b1, 1'b0, 1'b1);
    send_line();
    add(CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
    add(16'h007a, 1'b1, 1'b1, 1'b1);
    send_line();
    add(16'h0061, 1'b0, 1'b0, 1'b0);
    add(16'h0062, 1'b0, 1'b0, 1'b0);
    add(CH_OPEN_ROUND, 1'b0, 1'b0, 1'b0);
    add(16'h0063, 1'b0, 1'b0, 1'b0);
    add(CH_CLOSE_ROUND, 1'b1, 1'b0, 1'b1);
    send_line();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          push_idle_pct = 28;
          pop_idle_pct  = 49;
        end
        1: begin
          push_idle_pct = 49;
          pop_idle_pct  = 28;
        end
        default: begin
          push_idle_pct = 0;
          pop_idle_pct  = 0;
        end
      endcase
      target = items_sent + 105;
      while (items_sent < target) begin
        build_random_line();
        send_line();
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    $display("covered %0d lines, %0d items (%0d outside failed lines), %0d results checked",
             lines_sent, items_sent, live_items, results);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_bracket_group_joiner_unit: done, clean");
    end else begin
      $display("tb_bracket_group_joiner_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_bracket_group_joiner_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/bgj_pkg.sv
src/bgj_front.sv
src/bgj_cmd_queue.sv
src/bgj_back.sv
src/bracket_group_joiner_unit.sv
tb/sv/bgj_token_checker.sv
tb/sv/tb_bracket_group_joiner_unit.sv
